FILE: rtl/sstf_pkg.sv
// ----------------------------------------------------------------------------
// sstf_pkg
// Shared types and codes for the shortest-seek-first request scheduler.
// ----------------------------------------------------------------------------
package sstf_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    typedef enum logic {
        CMD_ENQ = 1'b0,
        CMD_DEQ = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        STS_ENQ   = 2'd0,
        STS_FULL  = 2'd1,
        STS_DEQ   = 2'd2,
        STS_EMPTY = 2'd3
    } t_status;

    typedef struct packed {
        t_cmd        command;
        logic [7:0]  device_id;
        logic        is_write;
        logic [31:0] start_block;
        logic [31:0] block_count;
        logic [15:0] request_tag;
        logic [31:0] head_position;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [7:0]  out_device_id;
        logic        out_is_write;
        logic [31:0] out_start_block;
        logic [31:0] out_block_count;
        logic [15:0] out_request_tag;
        logic [4:0]  occupancy;
    } t_rsp;

    // one stored request
    typedef struct packed {
        logic [7:0]  device_id;
        logic        is_write;
        logic [31:0] start_block;
        logic [31:0] block_count;
        logic [15:0] request_tag;
    } t_entry;

endpackage

FILE: rtl/sstf_mem.sv
// ----------------------------------------------------------------------------
// sstf_mem
// Request store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sstf_mem
    import sstf_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  t_entry                   i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output t_entry                   o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/sstf_disk_request_scheduler_top.sv
// ----------------------------------------------------------------------------
// sstf_disk_request_scheduler_top
// Pending block request queue with nearest-start-block dequeue.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its result appears on
// o_rsp for one cycle with o_done, and must be captured then. Enqueue, a full
// reject and an empty dequeue leave busy low, so a new item can follow at
// once. A dequeue holds busy while it scans and shifts, and strobes its result
// in the cycle that busy falls: one store read per entry to find the nearest
// start block (newest wins ties), then one move per entry above the removed
// slot, each down by one, to close the gap behind the removed request, all
// through the single read and single write port of the request store.
module sstf_disk_request_scheduler_top
    import sstf_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_done,
    output t_rsp o_rsp
);

    localparam int ADDR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_SHIFT = 3'b100
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_pending, n_pending;
    logic [ADDR_W-1:0]  r_cmp_idx, n_cmp_idx;
    logic [ADDR_W-1:0]  r_k, n_k;
    logic               r_sh_pend, n_sh_pend;
    logic [31:0]        r_head, n_head;
    logic [31:0]        r_best_gap, n_best_gap;
    logic [ADDR_W-1:0]  r_best_idx, n_best_idx;
    t_entry             r_best_ent, n_best_ent;
    logic               r_done, n_done;
    t_rsp               r_rsp, n_rsp;

    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    t_entry             mem_wdata;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_raddr;
    t_entry             mem_rdata;

    logic [31:0]        gap;
    logic [CNT_W-1:0]   sh_dst;
    logic [ADDR_W-1:0]  newest_idx;

    sstf_mem #(
        .DEPTH (QUEUE_DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign newest_idx = ADDR_W'(r_pending - 1'b1);
    assign gap = (r_head > mem_rdata.start_block) ? (r_head - mem_rdata.start_block)
                                                  : (mem_rdata.start_block - r_head);
    // slot that the next shift write lands in
    assign sh_dst = CNT_W'(r_k) + CNT_W'(r_sh_pend);

    always_comb begin
        n_state    = r_state;
        n_pending  = r_pending;
        n_cmp_idx  = r_cmp_idx;
        n_k        = r_k;
        n_sh_pend  = r_sh_pend;
        n_head     = r_head;
        n_best_gap = r_best_gap;
        n_best_idx = r_best_idx;
        n_best_ent = r_best_ent;
        n_done     = 1'b0;
        n_rsp      = r_rsp;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = '0;
        mem_re     = 1'b0;
        mem_raddr  = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    if (i_req.command == CMD_ENQ) begin
                        n_rsp = '0;
                        n_done = 1'b1;
                        if (r_pending >= CNT_W'(QUEUE_DEPTH)) begin
                            n_rsp.status = STS_FULL;
                        end else begin
                            mem_we                = 1'b1;
                            mem_waddr             = ADDR_W'(r_pending);
                            mem_wdata.device_id   = i_req.device_id;
                            mem_wdata.is_write    = i_req.is_write;
                            mem_wdata.start_block = i_req.start_block;
                            mem_wdata.block_count = i_req.block_count;
                            mem_wdata.request_tag = i_req.request_tag;
                            n_pending             = r_pending + 1'b1;
                            n_rsp.status          = STS_ENQ;
                        end
                        n_rsp.occupancy = 5'(n_pending);
                    end else if (r_pending == '0) begin
                        n_rsp           = '0;
                        n_rsp.status    = STS_EMPTY;
                        n_rsp.occupancy = 5'(r_pending);
                        n_done          = 1'b1;
                    end else begin
                        // scan newest to oldest
                        mem_re     = 1'b1;
                        mem_raddr  = newest_idx;
                        n_cmp_idx  = newest_idx;
                        n_head     = i_req.head_position;
                        n_best_gap = '1;
                        n_best_idx = newest_idx;
                        n_state    = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // strict compare keeps the newest on ties; newest entry is
                // always captured so an all-max-gap queue still returns it
                if (gap < r_best_gap || r_cmp_idx == newest_idx) begin
                    n_best_gap = gap;
                    n_best_idx = r_cmp_idx;
                    n_best_ent = mem_rdata;
                end
                if (r_cmp_idx != '0) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_cmp_idx - 1'b1;
                    n_cmp_idx = r_cmp_idx - 1'b1;
                end else begin
                    n_k       = n_best_idx;
                    n_sh_pend = 1'b0;
                    n_state   = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                // move each later entry down one slot, read k+1 then write k
                if (r_sh_pend) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_k;
                    mem_wdata = mem_rdata;
                end
                if (CNT_W'(sh_dst + 1'b1) < r_pending) begin
                    mem_re    = 1'b1;
                    mem_raddr = ADDR_W'(sh_dst + 1'b1);
                    n_k       = ADDR_W'(sh_dst);
                    n_sh_pend = 1'b1;
                end else begin
                    n_pending             = r_pending - 1'b1;
                    n_rsp.status          = STS_DEQ;
                    n_rsp.out_device_id   = r_best_ent.device_id;
                    n_rsp.out_is_write    = r_best_ent.is_write;
                    n_rsp.out_start_block = r_best_ent.start_block;
                    n_rsp.out_block_count = r_best_ent.block_count;
                    n_rsp.out_request_tag = r_best_ent.request_tag;
                    n_rsp.occupancy       = 5'(n_pending);
                    n_done                = 1'b1;
                    n_state               = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_pending <= '0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pending <= n_pending;
            r_done    <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx  <= n_cmp_idx;
        r_k        <= n_k;
        r_sh_pend  <= n_sh_pend;
        r_head     <= n_head;
        r_best_gap <= n_best_gap;
        r_best_idx <= n_best_idx;
        r_best_ent <= n_best_ent;
        r_rsp      <= n_rsp;
    end

    assign busy   = (r_state != ST_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

`ifndef ASSERT_OFF
    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= CNT_W'(QUEUE_DEPTH))
        else $error("pending count above queue depth");

    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("store read and write hit the same entry");

    a_busy_end_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> (o_done && o_rsp.status == STS_DEQ))
        else $error("dequeue ended without a result");

    a_deq_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SHIFT && n_state == ST_IDLE) |=> (r_pending == $past(r_pending) - 1'b1))
        else $error("dequeue did not remove one entry");
`endif

endmodule
